// File: hw/rtl/ips_pkg.sv
// ----------------------------------------------------------------------------
// ips_pkg
// Shared types and constants for the ignition power supervisor: modes,
// opcodes, configuration register map, item and result records.
// ----------------------------------------------------------------------------
package ips_pkg;

  localparam int CFG_W       = 24;
  localparam int NUM_CFG     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;

  typedef logic [CFG_W-1:0]     cfg_word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // configuration register map
  localparam cfg_idx_t CFG_IGNITION_STABLE = 3'd0;
  localparam cfg_idx_t CFG_CRANK_GRACE     = 3'd1;
  localparam cfg_idx_t CFG_BUS_IDLE_SLEEP  = 3'd2;
  localparam cfg_idx_t CFG_SCREEN_ON_DELAY = 3'd3;
  localparam cfg_idx_t CFG_IGNITION_LOSS   = 3'd4;
  localparam cfg_idx_t CFG_SHUTDOWN_PULSE  = 3'd5;
  localparam cfg_idx_t CFG_SHUTDOWN_GAP    = 3'd6;
  localparam cfg_idx_t CFG_POWERDOWN_WAIT  = 3'd7;

  localparam cfg_word_t CFG_RESET [NUM_CFG] = '{
    24'd500, 24'd3000, 24'd30000, 24'd2000,
    24'd2000, 24'd500, 24'd500, 24'd20000
  };

  typedef cfg_word_t ips_cfg_t [NUM_CFG];

  typedef enum logic [2:0] {
    MODE_WAIT    = 3'd0,
    MODE_RUN     = 3'd1,
    MODE_PULSE1  = 3'd2,
    MODE_GAP1    = 3'd3,
    MODE_PULSE2  = 3'd4,
    MODE_GAP2    = 3'd5,
    MODE_PDOWN   = 3'd6,
    MODE_SLEEP   = 3'd7
  } ips_mode_t;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_IGNITION = 2'd1,
    OP_BUS      = 2'd2,
    OP_RESET    = 2'd3
  } ips_op_t;

  typedef struct packed {
    ips_op_t     opcode;
    logic        ignition_on;
    logic        keep_dcdc_on;
    logic [31:0] now_ms;
  } ips_item_t;

  typedef struct packed {
    logic      dcdc_relay;
    logic      shutdown_relay;
    logic      screen_visible;
    ips_mode_t mode;
  } ips_result_t;

endpackage

// File: hw/rtl/ips_fsm.sv
// ----------------------------------------------------------------------------
// ips_fsm
// Supervisor state and its single-pass update: timers, flags and mode for
// one event per enabled cycle, with the result taken from the new state.
// ----------------------------------------------------------------------------
module ips_fsm #(
  parameter int IGNITION_GAP_RESET_MS = 1000,
  parameter int TIME_BITS             = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  ips_pkg::ips_item_t item,
  input  ips_pkg::ips_cfg_t  cfg,
  output ips_pkg::ips_result_t result
);
  import ips_pkg::*;

  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  typedef logic [TIME_BITS-1:0] time_t;

  ips_mode_t mode, mode_next;
  time_t on_since, on_since_next;
  time_t on_last_seen, on_last_seen_next;
  time_t off_since, off_since_next;
  time_t running_since, running_since_next;
  time_t grace_start, grace_start_next;
  time_t phase_start, phase_start_next;
  time_t shutdown_start, shutdown_start_next;
  time_t last_bus_frame, last_bus_frame_next;
  logic on_pend, on_pend_next;
  logic off_pend, off_pend_next;
  logic run_act, run_act_next;
  logic dcdc, dcdc_next;
  logic scr_pend, scr_pend_next;
  logic cut, cut_next;
  logic shut, shut_next;

  // wrapping elapsed test, durations wider than the time range never elapse
  function automatic logic elapsed(time_t t, cfg_word_t d, time_t now_t);
    time_t diff;
    diff = now_t - t;
    return CMP_W'(diff) >= CMP_W'(d);
  endfunction

  function automatic logic gap_over(time_t t, time_t now_t);
    time_t diff;
    diff = now_t - t;
    return CMP_W'(diff) > CMP_W'(IGNITION_GAP_RESET_MS);
  endfunction

  always_comb begin
    time_t now_t;
    logic  grace;
    logic  busy;
    logic  asleep;

    now_t  = TIME_BITS'(item.now_ms);
    grace  = 1'b0;
    busy   = 1'b0;
    asleep = 1'b0;

    mode_next           = mode;
    on_since_next       = on_since;
    on_last_seen_next   = on_last_seen;
    off_since_next      = off_since;
    running_since_next  = running_since;
    grace_start_next    = grace_start;
    phase_start_next    = phase_start;
    shutdown_start_next = shutdown_start;
    last_bus_frame_next = last_bus_frame;
    on_pend_next        = on_pend;
    off_pend_next       = off_pend;
    run_act_next        = run_act;
    dcdc_next           = dcdc;
    scr_pend_next       = scr_pend;
    cut_next            = cut;
    shut_next           = shut;

    case (item.opcode)
      OP_TICK: begin
        grace = (mode == MODE_RUN) && !elapsed(grace_start, cfg[CFG_CRANK_GRACE], now_t);
        busy  = on_pend || off_pend || run_act || (mode == MODE_RUN);
        if (mode == MODE_WAIT && !busy && last_bus_frame != '0 &&
            elapsed(last_bus_frame, cfg[CFG_BUS_IDLE_SLEEP], now_t)) begin
          // silent bus: fall asleep with a full return-to-wait clear
          mode_next           = MODE_SLEEP;
          run_act_next        = 1'b0;
          dcdc_next           = !cut;
          scr_pend_next       = 1'b0;
          on_pend_next        = 1'b0;
          on_since_next       = '0;
          on_last_seen_next   = '0;
          off_pend_next       = 1'b0;
          off_since_next      = '0;
          running_since_next  = '0;
          grace_start_next    = '0;
          phase_start_next    = '0;
          shutdown_start_next = '0;
          cut_next            = 1'b0;
          last_bus_frame_next = now_t;
          shut_next           = 1'b0;
        end
        asleep = (mode_next == MODE_SLEEP);

        if (!asleep) begin
          // qualification restarts on an ignition gap
          if (on_pend_next && on_last_seen_next != '0 &&
              gap_over(on_last_seen_next, now_t)) begin
            on_pend_next      = 1'b0;
            on_since_next     = '0;
            on_last_seen_next = '0;
            off_pend_next     = 1'b0;
            off_since_next    = '0;
          end

          case (mode_next)
            MODE_WAIT: begin
              if (on_pend_next &&
                  elapsed(on_since_next, cfg[CFG_IGNITION_STABLE], now_t)) begin
                mode_next          = MODE_RUN;
                run_act_next       = 1'b1;
                dcdc_next          = 1'b1;
                cut_next           = 1'b0;
                running_since_next = now_t;
                grace_start_next   = now_t;
                scr_pend_next      = 1'b1;
                on_pend_next       = 1'b0;
                on_since_next      = '0;
                off_pend_next      = 1'b0;
                off_since_next     = '0;
              end
            end
            MODE_RUN: begin
              if (scr_pend_next &&
                  elapsed(running_since_next, cfg[CFG_SCREEN_ON_DELAY], now_t)) begin
                scr_pend_next = 1'b0;
                if (off_pend_next && off_since_next == '0 && !grace) begin
                  off_since_next = now_t;
                end
              end else if (!scr_pend_next && off_pend_next && !grace) begin
                if (off_since_next == '0) begin
                  off_since_next = now_t;
                end
                if (elapsed(off_since_next, cfg[CFG_IGNITION_LOSS], now_t)) begin
                  mode_next           = MODE_PULSE1;
                  run_act_next        = 1'b0;
                  scr_pend_next       = 1'b0;
                  shut_next           = 1'b1;
                  cut_next            = 1'b0;
                  shutdown_start_next = now_t;
                  phase_start_next    = now_t;
                end
              end
            end
            MODE_PULSE1: begin
              if (elapsed(phase_start, cfg[CFG_SHUTDOWN_PULSE], now_t)) begin
                shut_next        = 1'b0;
                mode_next        = MODE_GAP1;
                phase_start_next = now_t;
              end
            end
            MODE_GAP1: begin
              if (elapsed(phase_start, cfg[CFG_SHUTDOWN_GAP], now_t)) begin
                shut_next        = 1'b1;
                mode_next        = MODE_PULSE2;
                phase_start_next = now_t;
              end
            end
            MODE_PULSE2: begin
              if (elapsed(phase_start, cfg[CFG_SHUTDOWN_PULSE], now_t)) begin
                shut_next        = 1'b0;
                mode_next        = MODE_GAP2;
                phase_start_next = now_t;
              end
            end
            MODE_GAP2: begin
              if (elapsed(phase_start, cfg[CFG_SHUTDOWN_GAP], now_t)) begin
                cut_next         = 1'b1;
                mode_next        = MODE_PDOWN;
                phase_start_next = now_t;
              end
            end
            MODE_PDOWN: begin
              if (elapsed(shutdown_start, cfg[CFG_POWERDOWN_WAIT], now_t)) begin
                mode_next           = MODE_WAIT;
                run_act_next        = 1'b0;
                dcdc_next           = !cut;
                scr_pend_next       = 1'b0;
                on_pend_next        = 1'b0;
                on_since_next       = '0;
                on_last_seen_next   = '0;
                off_pend_next       = 1'b0;
                off_since_next      = '0;
                running_since_next  = '0;
                grace_start_next    = '0;
                phase_start_next    = '0;
                shutdown_start_next = '0;
                cut_next            = 1'b0;
                last_bus_frame_next = now_t;
                shut_next           = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      OP_IGNITION: begin
        if (item.ignition_on) begin
          if (mode != MODE_RUN && mode != MODE_WAIT) begin
            // abort shutdown or sleep, qualification starts at once
            shut_next           = 1'b0;
            mode_next           = MODE_WAIT;
            run_act_next        = 1'b0;
            dcdc_next           = 1'b1;
            scr_pend_next       = 1'b0;
            cut_next            = 1'b0;
            on_pend_next        = 1'b1;
            on_since_next       = now_t;
            on_last_seen_next   = now_t;
            running_since_next  = '0;
            grace_start_next    = '0;
            phase_start_next    = '0;
            shutdown_start_next = '0;
          end
          if (!on_pend_next || on_last_seen_next == '0 ||
              gap_over(on_last_seen_next, now_t)) begin
            on_pend_next  = 1'b1;
            on_since_next = now_t;
          end
          on_last_seen_next = now_t;
          off_pend_next     = 1'b0;
          off_since_next    = '0;
        end else begin
          on_pend_next      = 1'b0;
          on_since_next     = '0;
          on_last_seen_next = '0;
          off_pend_next     = 1'b1;
          if (!scr_pend && off_since == '0) begin
            off_since_next = now_t;
          end
        end
      end

      OP_BUS: begin
        last_bus_frame_next = now_t;
      end

      default: begin
        // forced return to waiting
        mode_next           = MODE_WAIT;
        run_act_next        = 1'b0;
        dcdc_next           = item.keep_dcdc_on || !cut;
        scr_pend_next       = 1'b0;
        on_pend_next        = 1'b0;
        on_since_next       = '0;
        on_last_seen_next   = '0;
        off_pend_next       = 1'b0;
        off_since_next      = '0;
        running_since_next  = '0;
        grace_start_next    = '0;
        phase_start_next    = '0;
        shutdown_start_next = '0;
        cut_next            = 1'b0;
        last_bus_frame_next = now_t;
        shut_next           = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_WAIT;
      on_since       <= '0;
      on_last_seen   <= '0;
      off_since      <= '0;
      running_since  <= '0;
      grace_start    <= '0;
      phase_start    <= '0;
      shutdown_start <= '0;
      last_bus_frame <= '0;
      on_pend        <= 1'b0;
      off_pend       <= 1'b0;
      run_act        <= 1'b0;
      dcdc           <= 1'b0;
      scr_pend       <= 1'b0;
      cut            <= 1'b0;
      shut           <= 1'b0;
    end else if (step) begin
      mode           <= mode_next;
      on_since       <= on_since_next;
      on_last_seen   <= on_last_seen_next;
      off_since      <= off_since_next;
      running_since  <= running_since_next;
      grace_start    <= grace_start_next;
      phase_start    <= phase_start_next;
      shutdown_start <= shutdown_start_next;
      last_bus_frame <= last_bus_frame_next;
      on_pend        <= on_pend_next;
      off_pend       <= off_pend_next;
      run_act        <= run_act_next;
      dcdc           <= dcdc_next;
      scr_pend       <= scr_pend_next;
      cut            <= cut_next;
      shut           <= shut_next;
    end
  end

  assign result.dcdc_relay     = dcdc_next;
  assign result.shutdown_relay = shut_next;
  assign result.screen_visible = (mode_next == MODE_RUN) && !scr_pend_next;
  assign result.mode           = mode_next;

endmodule

// File: hw/rtl/ignition_power_supervisor.sv
// ----------------------------------------------------------------------------
// ignition_power_supervisor
// Vehicle power supervisor: ignition qualification, running, two-pulse
// shutdown request, power-down wait and bus sleep, driven by timed events.
// ----------------------------------------------------------------------------
// Each event on the slave stream (update tick, ignition frame, other bus
// frame or forced return to waiting, with a millisecond timestamp) gives
// exactly one status transaction on the master stream carrying the relay
// drives, screen visibility and mode. One event is taken every clock cycle
// unless the output stalls; an input register feeds a single update pass
// of the timers and flags that writes the result register. The output
// register lets a new event enter while a result still waits for tready.
// Configuration is always ready and should only be written while no event
// is in flight; it resets to the documented defaults.
module ignition_power_supervisor #(
  parameter int IGNITION_GAP_RESET_MS = 1000,
  parameter int TIME_BITS             = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ips_pkg::IN_TDATA_W-1:0]   s_tdata,   // ignition_on, keep_dcdc_on, now_ms, zeros
  input  logic [ips_pkg::IN_TUSER_W-1:0]   s_tuser,   // opcode
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ips_pkg::OUT_TDATA_W-1:0]  m_tdata,   // dcdc_relay, shutdown_relay,
                                                      // screen_visible, mode, zeros
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  ips_pkg::cfg_idx_t                cfg_index,
  input  ips_pkg::cfg_word_t               cfg_data
);
  import ips_pkg::*;

  ips_cfg_t    cfg;
  ips_item_t   in_item;
  logic        in_valid;
  ips_result_t out_res;
  logic        out_valid;
  ips_result_t res_next;
  logic        advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg[i] <= CFG_RESET[i];
      end
    end else if (cfg_valid) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.opcode       <= ips_op_t'(s_tuser);
      in_item.ignition_on  <= s_tdata[0];
      in_item.keep_dcdc_on <= s_tdata[1];
      in_item.now_ms       <= s_tdata[33:2];
    end
  end

  ips_fsm #(
    .IGNITION_GAP_RESET_MS (IGNITION_GAP_RESET_MS),
    .TIME_BITS             (TIME_BITS)
  ) u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res.mode, out_res.screen_visible,
                     out_res.shutdown_relay, out_res.dcdc_relay};

endmodule

// File: test/ignition_power_supervisor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ignition_power_supervisor_tb
// Self-checking bench for the ignition power supervisor. Timed events are
// streamed in and every status transaction is compared field by field with
// an in-bench model of the supervisor. The run covers directed corner
// cases, then drive cycles of key-on, key-off and quiet bus, under several
// register settings. Both stream sides idle at random, with one long hold
// on the status side.
// ----------------------------------------------------------------------------
module ignition_power_supervisor_tb;
  import ips_pkg::*;

  localparam logic [31:0] IGN_GAP_MS    = 32'd1000;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          PHASE_EVENTS  = 160;
  localparam int unsigned ON_STEP [6]   = '{450, 40, 300, 900, 450, 450};
  localparam int unsigned OFF_STEP [6]  = '{3000, 60, 300, 6000000, 2500, 3000};

  typedef enum {KEY_ON, KEY_OFF, BUS_QUIET} drive_regime_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [IN_TUSER_W-1:0]  s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index = '0;
  cfg_word_t              cfg_data  = '0;

  ips_item_t   pending_events [$];
  ips_result_t expected_status [$];
  ips_item_t   offered;
  logic [31:0] clock_ms = '0;
  int          errors = 0;
  int          issued = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  bit          held_once = 1'b0;
  int          stall_cycles = 0;

  // supervisor model state
  ips_cfg_t    cfg_model = CFG_RESET;
  ips_mode_t   sup_mode = MODE_WAIT;
  logic [31:0] on_since = '0, on_seen = '0, off_since = '0, run_since = '0;
  logic [31:0] grace_from = '0, phase_from = '0, shutdown_from = '0, bus_seen = '0;
  logic        on_pend = 1'b0, off_pend = 1'b0, run_act = 1'b0, dcdc_on = 1'b0;
  logic        scr_pend = 1'b0, cut_armed = 1'b0, shut_on = 1'b0;

  ignition_power_supervisor #(
    .IGNITION_GAP_RESET_MS(IGN_GAP_MS),
    .TIME_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // wrapping elapsed-time tests
  function automatic bit aged(input logic [31:0] t, input logic [31:0] d,
                              input logic [31:0] now);
    logic [31:0] diff;
    diff = now - t;
    return diff >= d;
  endfunction

  function automatic bit aged_strict(input logic [31:0] t, input logic [31:0] d,
                                     input logic [31:0] now);
    logic [31:0] diff;
    diff = now - t;
    return diff > d;
  endfunction

  function automatic void clear_ignition();
    on_pend   = 1'b0;
    on_since  = '0;
    on_seen   = '0;
    off_pend  = 1'b0;
    off_since = '0;
  endfunction

  function automatic void enter_waiting(input bit keep, input logic [31:0] now);
    sup_mode      = MODE_WAIT;
    run_act       = 1'b0;
    dcdc_on       = keep || !cut_armed;
    scr_pend      = 1'b0;
    clear_ignition();
    run_since     = '0;
    grace_from    = '0;
    phase_from    = '0;
    shutdown_from = '0;
    cut_armed     = 1'b0;
    bus_seen      = now;
    shut_on       = 1'b0;
  endfunction

  function automatic void phase_advance(input cfg_word_t dur, input ips_mode_t nxt_mode,
                                        input bit relay, input logic [31:0] now);
    if (aged(phase_from, dur, now)) begin
      shut_on    = relay;
      sup_mode   = nxt_mode;
      phase_from = now;
    end
  endfunction

  function automatic ips_result_t supervise(input ips_item_t ev);
    logic [31:0] now;
    bit          grace;
    bit          busy;
    ips_result_t r;
    now = ev.now_ms;
    case (ev.opcode)
      OP_TICK: begin
        grace = (sup_mode == MODE_RUN) && !aged(grace_from, cfg_model[CFG_CRANK_GRACE], now);
        busy  = on_pend || off_pend || run_act || sup_mode == MODE_RUN;
        if (sup_mode == MODE_WAIT && !busy && bus_seen != 0 &&
            aged(bus_seen, cfg_model[CFG_BUS_IDLE_SLEEP], now)) begin
          enter_waiting(1'b0, now);
          sup_mode = MODE_SLEEP;
        end
        // sleep ignores ticks altogether
        if (sup_mode != MODE_SLEEP) begin
          if (on_pend && on_seen != 0 && aged_strict(on_seen, IGN_GAP_MS, now))
            clear_ignition();
          case (sup_mode)
            MODE_WAIT: begin
              if (on_pend && aged(on_since, cfg_model[CFG_IGNITION_STABLE], now)) begin
                sup_mode   = MODE_RUN;
                run_act    = 1'b1;
                dcdc_on    = 1'b1;
                cut_armed  = 1'b0;
                run_since  = now;
                grace_from = now;
                scr_pend   = 1'b1;
                on_pend    = 1'b0;
                on_since   = '0;
                off_pend   = 1'b0;
                off_since  = '0;
              end
            end
            MODE_RUN: begin
              if (scr_pend && aged(run_since, cfg_model[CFG_SCREEN_ON_DELAY], now)) begin
                scr_pend = 1'b0;
                if (off_pend && off_since == 0 && !grace)
                  off_since = now;
              end else if (!scr_pend && off_pend && !grace) begin
                if (off_since == 0)
                  off_since = now;
                if (aged(off_since, cfg_model[CFG_IGNITION_LOSS], now)) begin
                  sup_mode      = MODE_PULSE1;
                  run_act       = 1'b0;
                  scr_pend      = 1'b0;
                  shut_on       = 1'b1;
                  cut_armed     = 1'b0;
                  shutdown_from = now;
                  phase_from    = now;
                end
              end
            end
            MODE_PULSE1: phase_advance(cfg_model[CFG_SHUTDOWN_PULSE], MODE_GAP1, 1'b0, now);
            MODE_GAP1:   phase_advance(cfg_model[CFG_SHUTDOWN_GAP], MODE_PULSE2, 1'b1, now);
            MODE_PULSE2: phase_advance(cfg_model[CFG_SHUTDOWN_PULSE], MODE_GAP2, 1'b0, now);
            MODE_GAP2: begin
              if (aged(phase_from, cfg_model[CFG_SHUTDOWN_GAP], now)) begin
                cut_armed  = 1'b1;
                sup_mode   = MODE_PDOWN;
                phase_from = now;
              end
            end
            MODE_PDOWN: begin
              if (aged(shutdown_from, cfg_model[CFG_POWERDOWN_WAIT], now))
                enter_waiting(1'b0, now);
            end
            default: ;
          endcase
        end
      end
      OP_IGNITION: begin
        if (ev.ignition_on) begin
          // key on during shutdown or sleep aborts straight back to waiting
          if (sup_mode != MODE_RUN && sup_mode != MODE_WAIT) begin
            shut_on       = 1'b0;
            sup_mode      = MODE_WAIT;
            run_act       = 1'b0;
            dcdc_on       = 1'b1;
            scr_pend      = 1'b0;
            cut_armed     = 1'b0;
            on_pend       = 1'b1;
            on_since      = now;
            on_seen       = now;
            off_pend      = 1'b0;
            off_since     = '0;
            run_since     = '0;
            grace_from    = '0;
            phase_from    = '0;
            shutdown_from = '0;
          end
          if (!on_pend || on_seen == 0 || aged_strict(on_seen, IGN_GAP_MS, now)) begin
            on_pend  = 1'b1;
            on_since = now;
          end
          on_seen   = now;
          off_pend  = 1'b0;
          off_since = '0;
        end else begin
          on_pend  = 1'b0;
          on_since = '0;
          on_seen  = '0;
          off_pend = 1'b1;
          if (!scr_pend && off_since == 0)
            off_since = now;
        end
      end
      OP_BUS: bus_seen = now;
      default: enter_waiting(ev.keep_dcdc_on, now);
    endcase
    r.dcdc_relay     = dcdc_on;
    r.shutdown_relay = shut_on;
    r.screen_visible = (sup_mode == MODE_RUN) && !scr_pend;
    r.mode           = sup_mode;
    return r;
  endfunction

  function automatic void push_event(input ips_op_t op, input logic ign, input logic keep,
                                     input logic [31:0] now);
    ips_item_t ev;
    ev.opcode       = op;
    ev.ignition_on  = ign;
    ev.keep_dcdc_on = keep;
    ev.now_ms       = now;
    pending_events.push_back(ev);
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // drive cycles: key on, key off, then a quiet bus, with some noise and resets
  task automatic queue_drive_pattern(input int n, input int unsigned on_max,
                                     input int unsigned off_max);
    drive_regime_t regime;
    int            left;
    int unsigned   roll;
    logic          ign;
    logic          keep;
    regime = KEY_ON;
    left   = $urandom_range(50, 10);
    repeat (n) begin
      if (left == 0) begin
        regime = (regime == KEY_ON) ? KEY_OFF : (regime == KEY_OFF) ? BUS_QUIET : KEY_ON;
        left   = $urandom_range(50, 10);
      end
      left--;
      roll = $urandom_range(99);
      ign  = 1'($urandom_range(1));
      keep = 1'($urandom_range(1));
      if (roll < 5) begin
        push_event(ips_op_t'(IN_TUSER_W'($urandom_range(3))), ign, keep, $urandom);
      end else begin
        clock_ms += $urandom_range(regime == KEY_ON ? on_max : off_max);
        if ($urandom_range(199) == 0)
          clock_ms += $urandom;
        if (roll < 7)
          push_event(OP_RESET, ign, keep, clock_ms);
        else if (regime == KEY_ON) begin
          if (roll < 52)      push_event(OP_TICK, ign, keep, clock_ms);
          else if (roll < 60) push_event(OP_BUS, ign, keep, clock_ms);
          else                push_event(OP_IGNITION, roll < 98, keep, clock_ms);
        end else if (regime == KEY_OFF) begin
          if (roll < 55)      push_event(OP_TICK, ign, keep, clock_ms);
          else if (roll < 68) push_event(OP_BUS, ign, keep, clock_ms);
          else                push_event(OP_IGNITION, 1'b0, keep, clock_ms);
        end else begin
          if (roll < 98)      push_event(OP_TICK, ign, keep, clock_ms);
          else                push_event(OP_BUS, ign, keep, clock_ms);
        end
      end
    end
  endtask

  task automatic write_register(input cfg_idx_t idx, input cfg_word_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_model[idx] = val;
  endtask

  // wait until every event is taken and every status transaction is back
  task automatic settle();
    @(negedge clk);
    while (pending_events.size() != 0 || s_tvalid || expected_status.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : event_driver
    ips_item_t nxt;
    bit        idle_now;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_status.push_back(supervise(offered));
      if (!s_tvalid || s_tready) begin
        idle_now = !(issued >= 600 && issued < 750) && $urandom_range(99) < 23;
        if (pending_events.size() != 0 && !idle_now) begin
          nxt = pending_events.pop_front();
          offered  <= nxt;
          s_tdata  <= {6'b0, nxt.now_ms, nxt.keep_dcdc_on, nxt.ignition_on};
          s_tuser  <= nxt.opcode;
          s_tvalid <= 1'b1;
          issued++;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : status_monitor
    ips_result_t want;
    bit          quiet;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_status.size() == 0) begin
          errors++;
          $display("%0t: status transaction with nothing expected, expected none, got %h",
                   $time, m_tdata);
        end else begin
          want = expected_status.pop_front();
          check_field("dcdc_relay", 32'(want.dcdc_relay), 32'(m_tdata[0]));
          check_field("shutdown_relay", 32'(want.shutdown_relay), 32'(m_tdata[1]));
          check_field("screen_visible", 32'(want.screen_visible), 32'(m_tdata[2]));
          check_field("mode", 32'(want.mode), 32'(m_tdata[5:3]));
        end
        results_seen++;
      end
      quiet = results_seen >= 600 && results_seen < 750;
      // one long hold so the block backs up and stalls its input
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!held_once && results_seen >= 300) begin
        held_once = 1'b1;
        hold_left = 80;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= 23);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned r;
    cfg_word_t   val;
    // directed walk through a full drive cycle at the default settings
    push_event(OP_TICK, 1'b0, 1'b0, 32'd0);
    push_event(OP_BUS, 1'b1, 1'b1, 32'hFFFF_FFFF);
    push_event(OP_RESET, 1'b0, 1'b1, 32'd1000);
    push_event(OP_IGNITION, 1'b1, 1'b0, 32'd2000);
    push_event(OP_IGNITION, 1'b1, 1'b0, 32'd3001);  // gap just over the limit restarts
    push_event(OP_TICK, 1'b0, 1'b0, 32'd3400);
    push_event(OP_IGNITION, 1'b1, 1'b0, 32'd3900);
    push_event(OP_TICK, 1'b0, 1'b0, 32'd3901);
    push_event(OP_IGNITION, 1'b0, 1'b0, 32'd4000);  // key off inside crank grace
    push_event(OP_TICK, 1'b0, 1'b0, 32'd5901);
    push_event(OP_TICK, 1'b0, 1'b0, 32'd6901);
    push_event(OP_TICK, 1'b0, 1'b0, 32'd8901);
    push_event(OP_TICK, 1'b0, 1'b0, 32'd9401);
    push_event(OP_TICK, 1'b0, 1'b0, 32'd9901);
    push_event(OP_TICK, 1'b0, 1'b0, 32'd10401);
    push_event(OP_TICK, 1'b0, 1'b0, 32'd10901);
    push_event(OP_TICK, 1'b0, 1'b0, 32'd28901);
    push_event(OP_TICK, 1'b0, 1'b0, 32'd58901);     // silent bus, falls asleep
    push_event(OP_TICK, 1'b0, 1'b0, 32'd70000);
    push_event(OP_IGNITION, 1'b1, 1'b0, 32'd70001); // key on wakes from sleep
    push_event(OP_IGNITION, 1'b1, 1'b0, 32'd71000);
    push_event(OP_IGNITION, 1'b0, 1'b0, 32'd71100);
    push_event(OP_RESET, 1'b1, 1'b0, 32'd0);        // zero timestamp leaves the bus unset
    push_event(OP_TICK, 1'b1, 1'b1, 32'hFFFF_FFFF);
    push_event(OP_IGNITION, 1'b1, 1'b1, 32'd0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < 6; ph++) begin
      settle();
      if (ph != 0) begin
        for (r = 0; r < NUM_CFG; r++) begin
          case (ph)
            1: val = cfg_word_t'($urandom_range(50));
            2: val = '0;
            3: val = '1;
            4: begin
              case ($urandom_range(5))
                0:       val = '0;
                1:       val = '1;
                default: val = cfg_word_t'($urandom_range(2500));
              endcase
            end
            default: val = CFG_RESET[r];
          endcase
          write_register(cfg_idx_t'(r), val);
        end
      end
      @(negedge clk);
      clock_ms = $urandom;
      queue_drive_pattern(PHASE_EVENTS, ON_STEP[ph], OFF_STEP[ph]);
    end

    settle();
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ips_pkg.sv
hw/rtl/ips_fsm.sv
hw/rtl/ignition_power_supervisor.sv
test/ignition_power_supervisor_tb.sv
